// ----- hdl/tpl_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, tables and types of the three-phase lfo core
package tpl_pkg;

    // sizes and field widths
    localparam int VOICES          = 16;
    localparam int VOICE_W         = 4;
    localparam int NV_W            = 5;
    localparam int CV_W            = 17;
    localparam int KNOB_W          = 17;
    localparam int ATTEN_W         = 16;
    localparam int SCALE_W         = 17;
    localparam int OFFSET_W        = 15;
    localparam int STEP_W          = 20;
    localparam int SAMPLE_W        = 16;
    localparam int LANE_W          = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 20;
    localparam int PHASE_BITS      = 32;
    localparam int INC_W           = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int FRAC_W          = 12;
    localparam int M_W             = 31;
    localparam int PM_W            = STEP_W + M_W;
    localparam int SH_W            = 6;
    localparam int X_W             = 17;
    localparam int S_W             = 31;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE_KNOB     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_ATTEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PER_HZ   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_VOICES = 3'd5;

    // register reset values
    localparam logic [KNOB_W-1:0]   RST_RATE_KNOB     = 17'd4096;
    localparam logic [ATTEN_W-1:0]  RST_RATE_ATTEN    = 16'd0;
    localparam logic [SCALE_W-1:0]  RST_SCALE         = 17'd65536;
    localparam logic [OFFSET_W-1:0] RST_OFFSET        = 15'd0;
    localparam logic [STEP_W-1:0]   RST_STEP_PER_HZ   = 20'd97391;
    localparam logic [NV_W-1:0]     RST_ACTIVE_VOICES = 5'd1;

    // lanes
    localparam logic [LANE_W-1:0] LANE_FIRST = 2'd0;
    localparam logic [LANE_W-1:0] LANE_LAST  = 2'd2;

    // rate and output arithmetic
    localparam logic signed [18:0] RATE_CLAMP = 19'sd20480;
    localparam logic signed [18:0] RATE_BIAS  = 19'sd12288;
    localparam logic signed [17:0] OUT_SAT    = 18'sd20480;
    localparam logic [M_W-1:0]     M_ONE      = 31'd1073741824;
    localparam logic [INC_W-1:0]   INC_LIM    = INC_W'(64'd1 << (PHASE_BITS - 1));

    // sine polynomial
    localparam logic [S_W-1:0] SINE_SEED = 31'd172272;
    localparam logic [31:0]    Y_MAX     = 32'd1073741824;
    localparam int             X_SHIFT   = 18 - SINE_TABLE_BITS;
    localparam logic [SINE_TABLE_BITS-2:0] QSIZE =
        (SINE_TABLE_BITS-1)'(1 << (SINE_TABLE_BITS - 2));

    // lane lags: one third and two thirds of a cycle, rounded
    localparam logic [63:0] LAG1_FULL = ((64'd1 << PHASE_BITS) + 64'd1) / 64'd3;
    localparam logic [63:0] LAG2_FULL = ((64'd2 << PHASE_BITS) + 64'd1) / 64'd3;

    // Q1.30 roots of two for each fraction bit
    function automatic logic [M_W-1:0] exp_root(input logic [3:0] b);
        logic [M_W-1:0] k;
        unique case (b)
            4'd0:    k = 31'd1073923544;
            4'd1:    k = 31'd1074105294;
            4'd2:    k = 31'd1074468888;
            4'd3:    k = 31'd1075196443;
            4'd4:    k = 31'd1076653033;
            4'd5:    k = 31'd1079572136;
            4'd6:    k = 31'd1085434106;
            4'd7:    k = 31'd1097253708;
            4'd8:    k = 31'd1121280436;
            4'd9:    k = 31'd1170923762;
            4'd10:   k = 31'd1276901417;
            4'd11:   k = 31'd1518500250;
            default: k = '0;
        endcase
        return k;
    endfunction

    // horner coefficients of the odd sine polynomial, outermost last
    function automatic logic [S_W-1:0] poly_coef(input logic [1:0] k);
        logic [S_W-1:0] c;
        unique case (k)
            2'd0:    c = 31'd5026996;
            2'd1:    c = 31'd85569305;
            2'd2:    c = 31'd693598674;
            default: c = 31'd1686629713;
        endcase
        return c;
    endfunction

    function automatic logic [PHASE_BITS-1:0] lane_lag(input logic [LANE_W-1:0] k);
        logic [PHASE_BITS-1:0] l;
        unique case (k)
            2'd0:    l = '0;
            2'd1:    l = LAG1_FULL[PHASE_BITS-1:0];
            default: l = LAG2_FULL[PHASE_BITS-1:0];
        endcase
        return l;
    endfunction

    // one voice request queued for the back end
    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [CV_W-1:0]    rate_cv;
        logic               upd;
    } t_job;

    // settings the back end works from
    typedef struct packed {
        logic [KNOB_W-1:0]   rate_knob;
        logic [ATTEN_W-1:0]  rate_atten;
        logic [SCALE_W-1:0]  scale;
        logic [OFFSET_W-1:0] offset;
        logic [STEP_W-1:0]   step_per_hz;
    } t_cfg;

endpackage

// ----- hdl/tpl_front.sv -----
`timescale 1ns / 1ps
// request intake: voice range check and frame divider
module tpl_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [tpl_pkg::NV_W-1:0]     i_active_voices,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [tpl_pkg::VOICE_W-1:0]  i_voice,
    input  logic [tpl_pkg::CV_W-1:0]     i_rate_cv,
    input  logic                         i_full,
    output logic                         o_push,
    output tpl_pkg::t_job                o_job
);
    import tpl_pkg::*;

    logic [1:0]      r_div;
    logic [NV_W-1:0] nv;
    logic            accept;
    logic            in_range;
    logic            frame_end;

    // effective voice count, clamped to 1..VOICES
    always_comb begin
        priority if (i_active_voices == '0) begin
            nv = NV_W'(1);
        end else if (i_active_voices > NV_W'(VOICES)) begin
            nv = NV_W'(VOICES);
        end else begin
            nv = i_active_voices;
        end
    end

    // classify the request
    assign accept    = i_valid && !i_full;
    assign in_range  = {1'b0, i_voice} < nv;
    assign frame_end = {1'b0, i_voice} == (nv - NV_W'(1));
    assign o_stall   = i_full;
    assign o_push    = accept && in_range;

    assign o_job.voice   = i_voice;
    assign o_job.rate_cv = i_rate_cv;
    assign o_job.upd     = (r_div == 2'd0);

    // frame divider: recompute increments every fourth frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= 2'd0;
        end else if (o_push && frame_end) begin
            r_div <= (r_div == 2'd0) ? 2'd3 : r_div - 2'd1;
        end
    end

endmodule

// ----- hdl/tpl_fifo.sv -----
`timescale 1ns / 1ps
// short request queue between front and back end
module tpl_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tpl_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tpl_pkg::t_job o_job
);
    import tpl_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop && o_valid) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            unique case ({i_push && !o_full, i_pop && o_valid})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hdl/tpl_back.sv -----
`timescale 1ns / 1ps
// sequenced datapath: increment, phase and three sine outputs on one multiplier
module tpl_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tpl_pkg::t_cfg                       i_cfg,
    input  logic                                i_job_vld,
    input  tpl_pkg::t_job                       i_job,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [tpl_pkg::LANE_W-1:0]          o_phase_lane,
    output logic signed [tpl_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                o_last
);
    import tpl_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PROD  = 4'd1;
    localparam logic [3:0] S_RATE  = 4'd2;
    localparam logic [3:0] S_EXP   = 4'd3;
    localparam logic [3:0] S_STEP  = 4'd4;
    localparam logic [3:0] S_SHIFT = 4'd5;
    localparam logic [3:0] S_ADV   = 4'd6;
    localparam logic [3:0] S_SQ    = 4'd7;
    localparam logic [3:0] S_POLY  = 4'd8;
    localparam logic [3:0] S_Y     = 4'd9;
    localparam logic [3:0] S_AMP   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // per-voice state
    logic [PHASE_BITS-1:0] r_phase [VOICES];
    logic [INC_W-1:0]      r_incr  [VOICES];
    logic [VOICES-1:0]     r_ph_vld;
    logic [VOICES-1:0]     r_inc_vld;

    // working registers
    logic [VOICE_W-1:0]       r_voice;
    logic [CV_W-1:0]          r_cv;
    logic                     r_upd;
    logic signed [32:0]       r_sp;
    logic [FRAC_W-1:0]        r_f;
    logic [SH_W-1:0]          r_sh;
    logic [M_W-1:0]           r_m;
    logic [3:0]               r_bit;
    logic [PM_W-1:0]          r_pm;
    logic [INC_W-1:0]         r_inc;
    logic [PHASE_BITS-1:0]    r_ph;
    logic [LANE_W-1:0]        r_lane;
    logic [X_W-1:0]           r_x;
    logic [X_W-1:0]           r_x2;
    logic [S_W-1:0]           r_s;
    logic [1:0]               r_k;
    logic [30:0]              r_y;
    logic                     r_neg;
    logic signed [SAMPLE_W-1:0] r_smp;

    // output register
    logic                       r_ovld;
    logic [LANE_W-1:0]          r_olane;
    logic signed [SAMPLE_W-1:0] r_osmp;
    logic                       r_olast;

    // combinational datapath
    logic [31:0]                 mul_a;
    logic [31:0]                 mul_b;
    logic [63:0]                 mul_p;
    logic signed [32:0]          sp_full;
    logic signed [18:0]          prod_raw;
    logic signed [18:0]          prod_c;
    logic signed [18:0]          knob_ext;
    logic signed [18:0]          c_val;
    logic signed [7:0]           sh_val;
    logic [63:0]                 m_rnd;
    logic [PM_W-1:0]             shv;
    logic [INC_W-1:0]            inc_sat;
    logic [INC_W-1:0]            inc_cur;
    logic [PHASE_BITS-1:0]       ph_cur;
    logic [PHASE_BITS-1:0]       ph_next;
    logic [PHASE_BITS-1:0]       lane_ph;
    logic [SINE_TABLE_BITS-1:0]  idx;
    logic [1:0]                  quad;
    logic [SINE_TABLE_BITS-2:0]  rr;
    logic [X_W-1:0]              sq_x;
    logic [31:0]                 y_raw;
    logic [30:0]                 amp_k;
    logic [63:0]                 t_sum;
    logic [15:0]                 t_mag;
    logic signed [17:0]          t_s;
    logic signed [17:0]          amp_sum;
    logic signed [SAMPLE_W-1:0]  smp_sat;
    logic                        out_free;

    assign o_pop    = (r_state == S_IDLE) && i_job_vld;
    assign out_free = !r_ovld || !i_stall;

    // cv times attenuverter
    assign sp_full = $signed(r_cv) * $signed(i_cfg.rate_atten);

    // clamped product plus knob and bias; exponent gives the shift (13..54)
    always_comb begin
        prod_raw = r_sp[32:14];
        priority if (prod_raw > RATE_CLAMP) begin
            prod_c = RATE_CLAMP;
        end else if (prod_raw < -RATE_CLAMP) begin
            prod_c = -RATE_CLAMP;
        end else begin
            prod_c = prod_raw;
        end
        knob_ext = $signed({{2{i_cfg.rate_knob[KNOB_W-1]}}, i_cfg.rate_knob});
        c_val    = knob_ext + prod_c - RATE_BIAS;
        sh_val   = 8'sd30 - $signed({c_val[18], c_val[18:12]});
    end

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_EXP: begin
                mul_a = 32'(r_m);
                mul_b = 32'(exp_root(r_bit));
            end
            S_STEP: begin
                mul_a = 32'(i_cfg.step_per_hz);
                mul_b = 32'(r_m);
            end
            S_SQ: begin
                mul_a = 32'(sq_x);
                mul_b = 32'(sq_x);
            end
            S_POLY: begin
                mul_a = 32'(r_s);
                mul_b = 32'(r_x2);
            end
            S_Y: begin
                mul_a = 32'(r_s);
                mul_b = 32'(r_x);
            end
            S_AMP: begin
                mul_a = 32'(r_y);
                mul_b = 32'(amp_k);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // exp2 step, shift and saturation of the increment
    assign m_rnd   = mul_p + (64'd1 << 29);
    assign shv     = r_pm >> r_sh;
    assign inc_sat = (shv > PM_W'(INC_LIM)) ? INC_LIM : shv[INC_W-1:0];

    // phase advance
    assign inc_cur = r_upd ? r_inc : (r_inc_vld[r_voice] ? r_incr[r_voice] : '0);
    assign ph_cur  = r_ph_vld[r_voice] ? r_phase[r_voice] : '0;
    assign ph_next = ph_cur + inc_cur[PHASE_BITS-1:0];

    // lane phase folded to the first quadrant
    always_comb begin
        lane_ph = r_ph - lane_lag(r_lane);
        idx     = lane_ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
        quad    = idx[SINE_TABLE_BITS-1 -: 2];
        rr      = {1'b0, idx[SINE_TABLE_BITS-3:0]};
        if (quad[0]) begin
            rr = QSIZE - rr;
        end
        sq_x = X_W'(rr) << X_SHIFT;
    end

    // sine result, clamped to one
    assign y_raw = mul_p[47:16];

    // amplitude: 5 V times scale, rounded, then offset and saturation
    always_comb begin
        amp_k   = 31'({i_cfg.scale, 13'd0}) + 31'({i_cfg.scale, 11'd0});
        t_sum   = mul_p + (64'd1 << 45);
        t_mag   = t_sum[61:46];
        t_s     = $signed({2'b00, t_mag});
        amp_sum = (r_neg ? -t_s : t_s)
                + $signed({{3{i_cfg.offset[OFFSET_W-1]}}, i_cfg.offset});
        priority if (amp_sum > OUT_SAT) begin
            smp_sat = SAMPLE_W'(OUT_SAT);
        end else if (amp_sum < -OUT_SAT) begin
            smp_sat = SAMPLE_W'(-OUT_SAT);
        end else begin
            smp_sat = amp_sum[SAMPLE_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_vld) begin
                    n_state = i_job.upd ? S_PROD : S_ADV;
                end
            end
            S_PROD:  n_state = S_RATE;
            S_RATE:  n_state = S_EXP;
            S_EXP: begin
                if (r_bit == 4'd0) begin
                    n_state = S_STEP;
                end
            end
            S_STEP:  n_state = S_SHIFT;
            S_SHIFT: n_state = S_ADV;
            S_ADV:   n_state = S_SQ;
            S_SQ:    n_state = S_POLY;
            S_POLY: begin
                if (r_k == 2'd3) begin
                    n_state = S_Y;
                end
            end
            S_Y:     n_state = S_AMP;
            S_AMP:   n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = (r_lane == LANE_LAST) ? S_IDLE : S_SQ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state, valid bits and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ph_vld  <= '0;
            r_inc_vld <= '0;
            r_ovld    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SHIFT) begin
                r_inc_vld[r_voice] <= 1'b1;
            end
            if (r_state == S_ADV) begin
                r_ph_vld[r_voice] <= 1'b1;
            end
            if (r_state == S_OUT && out_free) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_job_vld) begin
                    r_voice <= i_job.voice;
                    r_cv    <= i_job.rate_cv;
                    r_upd   <= i_job.upd;
                end
            end
            S_PROD: begin
                r_sp <= sp_full;
            end
            S_RATE: begin
                r_f   <= c_val[FRAC_W-1:0];
                r_sh  <= sh_val[SH_W-1:0];
                r_m   <= M_ONE;
                r_bit <= 4'(FRAC_W - 1);
            end
            S_EXP: begin
                if (r_f[r_bit]) begin
                    r_m <= m_rnd[60:30];
                end
                r_bit <= r_bit - 4'd1;
            end
            S_STEP: begin
                r_pm <= mul_p[PM_W-1:0];
            end
            S_SHIFT: begin
                r_inc            <= inc_sat;
                r_incr[r_voice]  <= inc_sat;
            end
            S_ADV: begin
                r_ph             <= ph_next;
                r_phase[r_voice] <= ph_next;
                r_lane           <= LANE_FIRST;
            end
            S_SQ: begin
                r_x   <= sq_x;
                r_x2  <= mul_p[16 +: X_W];
                r_neg <= quad[1];
                r_s   <= SINE_SEED;
                r_k   <= 2'd0;
            end
            S_POLY: begin
                r_s <= poly_coef(r_k) - mul_p[16 +: S_W];
                r_k <= r_k + 2'd1;
            end
            S_Y: begin
                r_y <= (y_raw > Y_MAX) ? Y_MAX[30:0] : y_raw[30:0];
            end
            S_AMP: begin
                r_smp <= smp_sat;
            end
            S_OUT: begin
                if (out_free) begin
                    r_olane <= r_lane;
                    r_osmp  <= r_smp;
                    r_olast <= (r_lane == LANE_LAST);
                    r_lane  <= r_lane + LANE_W'(1);
                end
            end
            default: begin
                r_lane <= r_lane;
            end
        endcase
    end

    assign o_valid      = r_ovld;
    assign o_phase_lane = r_olane;
    assign o_sample     = r_osmp;
    assign o_last       = r_olast;

    // the closing result of a request is always the two-thirds lane
    a_last_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_olast) |-> (r_olane == LANE_LAST))
        else $error("last flag on a lane other than the final one");

    // outputs stay inside plus minus ten volts
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> (r_osmp <= SAMPLE_W'(OUT_SAT) && r_osmp >= SAMPLE_W'(-OUT_SAT)))
        else $error("sample outside saturation range");

    // a popped request goes either through rate update or straight to the phase step
    a_pop_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_PROD || r_state == S_ADV))
        else $error("request popped but sequencer did not start");

    // a delivered result always frees the sequencer to the next lane or idle
    a_out_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (r_state == S_SQ || r_state == S_IDLE))
        else $error("sequencer stuck after handing over a result");

endmodule

// ----- hdl/three_phase_polyphonic_lfo_core.sv -----
`timescale 1ns / 1ps
// top level of the three-phase polyphonic lfo: settings, intake, queue, datapath
// A request that recomputes its increment (every fourth frame) first runs the rate update
// steps, then every request runs the sine steps for each output lane on one shared multiplier.
// The datapath pops the next request only after the previous one's last lane is handed over.
// Reset is synchronous, active low: settings return to defaults, voices to zero phase.
module three_phase_polyphonic_lfo_core
    import tpl_pkg::*;
(
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tpl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tpl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [tpl_pkg::VOICE_W-1:0]         i_voice,
    input  logic signed [tpl_pkg::CV_W-1:0]     i_rate_cv,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [tpl_pkg::LANE_W-1:0]          o_phase_lane,
    output logic signed [tpl_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                o_last
);

    t_cfg            r_cfg;
    logic [NV_W-1:0] r_active_voices;
    logic            push;
    logic            full;
    logic            pop;
    logic            job_vld;
    t_job            front_job;
    t_job            back_job;

    // settings register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_knob   <= RST_RATE_KNOB;
            r_cfg.rate_atten  <= RST_RATE_ATTEN;
            r_cfg.scale       <= RST_SCALE;
            r_cfg.offset      <= RST_OFFSET;
            r_cfg.step_per_hz <= RST_STEP_PER_HZ;
            r_active_voices   <= RST_ACTIVE_VOICES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RATE_KNOB:     r_cfg.rate_knob   <= i_cfg_data[KNOB_W-1:0];
                REG_RATE_ATTEN:    r_cfg.rate_atten  <= i_cfg_data[ATTEN_W-1:0];
                REG_SCALE:         r_cfg.scale       <= i_cfg_data[SCALE_W-1:0];
                REG_OFFSET:        r_cfg.offset      <= i_cfg_data[OFFSET_W-1:0];
                REG_STEP_PER_HZ:   r_cfg.step_per_hz <= i_cfg_data[STEP_W-1:0];
                REG_ACTIVE_VOICES: r_active_voices   <= i_cfg_data[NV_W-1:0];
                default:           r_active_voices   <= r_active_voices;
            endcase
        end
    end

    // intake
    tpl_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_active_voices (r_active_voices),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_voice         (i_voice),
        .i_rate_cv       (i_rate_cv),
        .i_full          (full),
        .o_push          (push),
        .o_job           (front_job)
    );

    // request queue
    tpl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_vld),
        .o_job   (back_job)
    );

    // datapath
    tpl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_job_vld    (job_vld),
        .i_job        (back_job),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_phase_lane (o_phase_lane),
        .o_sample     (o_sample),
        .o_last       (o_last)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// self-checking bench for the three-phase polyphonic lfo core: directed table, then random frames
module testbench;
    import tpl_pkg::*;

    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 62;
    localparam int DIR_ROWS     = 43;

    // indexes outside the register map, written to show they are ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

    localparam logic [63:0] INC_CEILING = 64'd1 << (PHASE_BITS - 1);

    // one output lane as the block should deliver it
    typedef struct packed {
        logic [LANE_W-1:0]          lane;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } lane_res_t;

    typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;

    // directed stimulus row; typed_mask marks lanes whose sample is given here
    typedef struct {
        row_kind_e            kind;
        logic [CFG_IDX_W-1:0] idx;
        int                   voice;
        int                   value;
        logic [2:0]           typed_mask;
        int                   typed_sample;
    } stim_row_t;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;
    logic                       i_valid;
    logic                       o_stall;
    logic [VOICE_W-1:0]         i_voice;
    logic signed [CV_W-1:0]     i_rate_cv;
    logic                       o_valid;
    logic                       i_stall;
    logic [LANE_W-1:0]          o_phase_lane;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic                       o_last;

    three_phase_polyphonic_lfo_core dut (.*);

    // Q1.30 factors 2^(2^b / 4096) for each fraction bit of the rate
    logic [63:0] root_q30 [12] = '{
        64'd1073923544, 64'd1074105294, 64'd1074468888, 64'd1075196443,
        64'd1076653033, 64'd1079572136, 64'd1085434106, 64'd1097253708,
        64'd1121280436, 64'd1170923762, 64'd1276901417, 64'd1518500250
    };

    // settings and voice state mirrored by the predictor
    logic [KNOB_W-1:0]   knob_r;
    logic [ATTEN_W-1:0]  atten_r;
    logic [SCALE_W-1:0]  scale_r;
    logic [OFFSET_W-1:0] offset_r;
    logic [STEP_W-1:0]   step_r;
    logic [NV_W-1:0]     nv_r;
    logic [31:0]         voice_phase [VOICES];
    logic [31:0]         voice_inc [VOICES];
    logic [1:0]          frame_div;

    lane_res_t expected_lanes [$];
    int        errors;
    int        burst_left;
    bit        hold_req;

    stim_row_t dir_rows [DIR_ROWS] = '{
        // first voice after reset: phase still near zero, lane 0 reads zero
        '{ROW_REQ, '0, 0, 0, 3'b001, 0},
        // voices past the active count, then voice 0 at cv extremes and writes to unused indexes
        '{ROW_REQ, '0, 1, 0, 3'b000, 0},
        '{ROW_REQ, '0, 15, 0, 3'b000, 0},
        '{ROW_REQ, '0, 0, 40960, 3'b000, 0},
        '{ROW_REQ, '0, 0, -40960, 3'b000, 0},
        '{ROW_REQ, '0, 0, 0, 3'b000, 0},
        '{ROW_CFG, REG_UNUSED_6, 0, 12345, 3'b000, 0},
        '{ROW_CFG, REG_UNUSED_7, 0, -1, 3'b000, 0},
        // full positive attenuation, top knob, cv clamp both ways
        '{ROW_CFG, REG_RATE_ATTEN, 0, 16384, 3'b000, 0},
        '{ROW_CFG, REG_RATE_KNOB, 0, 40960, 3'b000, 0},
        '{ROW_REQ, '0, 0, 40960, 3'b000, 0},
        '{ROW_REQ, '0, 0, -40960, 3'b000, 0},
        '{ROW_REQ, '0, 0, 65535, 3'b000, 0},
        '{ROW_REQ, '0, 0, -65536, 3'b000, 0},
        // full negative attenuation, bottom knob, largest step
        '{ROW_CFG, REG_RATE_ATTEN, 0, -16384, 3'b000, 0},
        '{ROW_CFG, REG_RATE_KNOB, 0, -32768, 3'b000, 0},
        '{ROW_CFG, REG_STEP_PER_HZ, 0, 1048575, 3'b000, 0},
        '{ROW_REQ, '0, 0, 40960, 3'b000, 0},
        '{ROW_REQ, '0, 0, -40960, 3'b000, 0},
        '{ROW_REQ, '0, 0, 0, 3'b000, 0},
        '{ROW_REQ, '0, 0, -65536, 3'b000, 0},
        // out-of-range knob and attenuverter: increment saturates
        '{ROW_CFG, REG_RATE_KNOB, 0, 65535, 3'b000, 0},
        '{ROW_CFG, REG_RATE_ATTEN, 0, -32768, 3'b000, 0},
        '{ROW_REQ, '0, 0, -65536, 3'b000, 0},
        '{ROW_REQ, '0, 0, 65535, 3'b000, 0},
        // zero scale leaves only the offset; zero active voices acts as one
        '{ROW_CFG, REG_SCALE, 0, 0, 3'b000, 0},
        '{ROW_CFG, REG_OFFSET, 0, 10240, 3'b000, 0},
        '{ROW_CFG, REG_ACTIVE_VOICES, 0, 0, 3'b000, 0},
        '{ROW_REQ, '0, 0, 0, 3'b111, 10240},
        '{ROW_REQ, '0, 1, 0, 3'b000, 0},
        // active voices above the voice count acts as all voices
        '{ROW_CFG, REG_OFFSET, 0, -10240, 3'b000, 0},
        '{ROW_CFG, REG_ACTIVE_VOICES, 0, 31, 3'b000, 0},
        '{ROW_CFG, REG_STEP_PER_HZ, 0, 1, 3'b000, 0},
        '{ROW_REQ, '0, 15, 0, 3'b111, -10240},
        '{ROW_REQ, '0, 3, 12345, 3'b111, -10240},
        // oversized scale and offset push the output into saturation
        '{ROW_CFG, REG_SCALE, 0, 131071, 3'b000, 0},
        '{ROW_CFG, REG_OFFSET, 0, 16383, 3'b000, 0},
        '{ROW_CFG, REG_ACTIVE_VOICES, 0, 16, 3'b000, 0},
        '{ROW_CFG, REG_STEP_PER_HZ, 0, 1048575, 3'b000, 0},
        '{ROW_REQ, '0, 0, 40960, 3'b000, 0},
        '{ROW_CFG, REG_OFFSET, 0, -16384, 3'b000, 0},
        '{ROW_REQ, '0, 1, 0, 3'b000, 0},
        '{ROW_REQ, '0, 15, -40960, 3'b000, 0}
    };

    // predictor: settings and state back to their reset values
    function automatic void clear_model();
        knob_r    = 17'd4096;
        atten_r   = 16'd0;
        scale_r   = 17'd65536;
        offset_r  = 15'd0;
        step_r    = 20'd97391;
        nv_r      = 5'd1;
        frame_div = 2'd0;
        for (int k = 0; k < VOICES; k++) begin
            voice_phase[k] = '0;
            voice_inc[k]   = '0;
        end
    endfunction

    function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_RATE_KNOB:     knob_r   = d[KNOB_W-1:0];
            REG_RATE_ATTEN:    atten_r  = d[ATTEN_W-1:0];
            REG_SCALE:         scale_r  = d[SCALE_W-1:0];
            REG_OFFSET:        offset_r = d[OFFSET_W-1:0];
            REG_STEP_PER_HZ:   step_r   = d[STEP_W-1:0];
            REG_ACTIVE_VOICES: nv_r     = d[NV_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int active_count();
        int n;
        n = int'(nv_r);
        if (n == 0) n = 1;
        if (n > VOICES) n = VOICES;
        return n;
    endfunction

    // phase step from knob, attenuated cv and the -3 V bias through exp2
    function automatic logic [31:0] calc_increment(input logic [CV_W-1:0] cv);
        longint      p, prod, c, e, sh;
        logic [11:0] f;
        logic [63:0] m, pm, v;
        p    = longint'($signed(cv)) * longint'($signed(atten_r));
        prod = p >>> 14;
        if (prod > 20480) prod = 20480;
        if (prod < -20480) prod = -20480;
        c = longint'($signed(knob_r)) + prod - 12288;
        e = c >>> 12;
        f = 12'(c);
        m = 64'd1 << 30;
        for (int b = 11; b >= 0; b--)
            if (f[b]) m = (m * root_q30[b] + (64'd1 << 29)) >> 30;
        pm = 64'(step_r) * m;
        sh = 30 - e;
        if (sh <= 0) v = (pm != 0) ? INC_CEILING : 64'd0;
        else if (sh >= 64) v = 64'd0;
        else v = pm >> sh;
        if (v > INC_CEILING) v = INC_CEILING;
        return v[31:0];
    endfunction

    // Q30 sine from the top table bits, quarter-wave folded, odd polynomial
    function automatic longint sine_of(input logic [PHASE_BITS-1:0] lp);
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [1:0]                 quad;
        logic [63:0]                r, x, x2, s, y;
        idx  = SINE_TABLE_BITS'(lp >> (PHASE_BITS - SINE_TABLE_BITS));
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        r    = 64'(idx[SINE_TABLE_BITS-3:0]);
        if (quad[0]) r = (64'd1 << (SINE_TABLE_BITS - 2)) - r;
        x  = r << (18 - SINE_TABLE_BITS);
        x2 = (x * x) >> 16;
        s  = 64'd172272;
        s  = 64'd5026996 - ((s * x2) >> 16);
        s  = 64'd85569305 - ((s * x2) >> 16);
        s  = 64'd693598674 - ((s * x2) >> 16);
        s  = 64'd1686629713 - ((s * x2) >> 16);
        y  = (s * x) >> 16;
        if (y > (64'd1 << 30)) y = 64'd1 << 30;
        return quad[1] ? -longint'(y) : longint'(y);
    endfunction

    // scale to 5 V times scale, add offset, saturate to +-10 V
    function automatic logic [SAMPLE_W-1:0] volts_of(input longint y);
        logic [63:0] mag, t;
        longint      v;
        mag = (y < 0) ? 64'(-y) : 64'(y);
        t   = (mag * 64'd10240 * 64'(scale_r) + (64'd1 << 45)) >> 46;
        v   = ((y < 0) ? -longint'(t) : longint'(t)) + longint'($signed(offset_r));
        if (v > 20480) v = 20480;
        if (v < -20480) v = -20480;
        return SAMPLE_W'(v);
    endfunction

    // advance one voice and queue its three lanes; typed lanes override the sample
    function automatic bit predict_voice(input logic [VOICE_W-1:0] v,
                                         input logic [CV_W-1:0] cv,
                                         input logic [2:0] typed_mask,
                                         input logic [SAMPLE_W-1:0] typed_val);
        int                    n;
        bit                    upd;
        logic [63:0]           lag;
        logic [PHASE_BITS-1:0] lp;
        lane_res_t             r;
        n = active_count();
        if (int'(v) >= n) return 1'b0;
        upd = (frame_div == 2'd0);
        if (upd) voice_inc[v] = calc_increment(cv);
        voice_phase[v] = voice_phase[v] + voice_inc[v];
        for (int k = 0; k < 3; k++) begin
            lag      = ((64'(k) << PHASE_BITS) + 64'd1) / 64'd3;
            lp       = voice_phase[v] - lag[PHASE_BITS-1:0];
            r.lane   = LANE_W'(k);
            r.sample = typed_mask[k] ? typed_val : volts_of(sine_of(lp));
            r.last   = (r.lane == LANE_LAST);
            expected_lanes.push_back(r);
        end
        if (int'(v) == n - 1) frame_div = upd ? 2'd3 : frame_div - 2'd1;
        return 1'b1;
    endfunction

    function automatic int rand_cv();
        case ($urandom_range(0, 9))
            0:       return 40960;
            1:       return -40960;
            2:       return int'($urandom_range(0, 131071)) - 65536;
            default: return int'($urandom_range(0, 81920)) - 40960;
        endcase
    endfunction

    // register write, only issued while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        set_reg(idx, d);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering, wait for every lane, then let any ignored request drain
    task automatic quiesce();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_lanes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // offer one request, predict it on acceptance, then maybe end the burst
    task automatic offer_request(input int voice, input int cv, input logic [2:0] typed_mask,
                                 input int typed_val, output bit counted);
        int gap;
        i_valid   <= 1'b1;
        i_voice   <= VOICE_W'(voice);
        i_rate_cv <= CV_W'(cv);
        do @(posedge i_clk); while (o_stall);
        counted = predict_voice(VOICE_W'(voice), CV_W'(cv), typed_mask, SAMPLE_W'(typed_val));
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
        end
    endtask

    // one full setting per random phase: a nominal setting and fixed extremes first, then random ones
    task automatic apply_setting(input int ph);
        int knob_v, atten_v, scale_v, offset_v, step_v, nv_v;
        case (ph)
            0: begin
                knob_v = 4096; atten_v = 8192; scale_v = 65536;
                offset_v = 0; step_v = 97391; nv_v = 4;
            end
            1: begin
                knob_v = -32768; atten_v = -16384; scale_v = 0;
                offset_v = -10240; step_v = 1; nv_v = 1;
            end
            2: begin
                knob_v = 40960; atten_v = 16384; scale_v = 65536;
                offset_v = 10240; step_v = 1048575; nv_v = 16;
            end
            3: begin
                knob_v = -65536; atten_v = -32768; scale_v = 131071;
                offset_v = 16383; step_v = 0; nv_v = 0;
            end
            4: begin
                knob_v = 65535; atten_v = 32767; scale_v = 40000;
                offset_v = -16384; step_v = 1048575; nv_v = 31;
            end
            default: begin
                knob_v   = int'($urandom_range(0, 73728)) - 32768;
                atten_v  = int'($urandom_range(0, 32768)) - 16384;
                scale_v  = $urandom_range(0, 65536);
                offset_v = int'($urandom_range(0, 20480)) - 10240;
                step_v   = $urandom_range(1, 1048575);
                nv_v     = $urandom_range(1, 16);
            end
        endcase
        write_reg(REG_RATE_KNOB, CFG_DATA_W'(knob_v));
        write_reg(REG_RATE_ATTEN, CFG_DATA_W'(atten_v));
        write_reg(REG_SCALE, CFG_DATA_W'(scale_v));
        write_reg(REG_OFFSET, CFG_DATA_W'(offset_v));
        write_reg(REG_STEP_PER_HZ, CFG_DATA_W'(step_v));
        write_reg(REG_ACTIVE_VOICES, CFG_DATA_W'(nv_v));
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin : stall_pattern
        int mode, len, run;
        bit stall_now;
        run       = 0;
        stall_now = 1'b0;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(20, 200);
                for (int c = 0; c < len; c++) begin
                    case (mode)
                        0: i_stall <= 1'b0;
                        1: i_stall <= ($urandom_range(0, 1) == 1);
                        2: i_stall <= ((c % 5) < 2);
                        default: begin
                            if (run == 0) begin
                                run       = $urandom_range(1, 12);
                                stall_now = !stall_now;
                            end
                            run--;
                            i_stall <= stall_now;
                        end
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // compare each accepted lane with the oldest expectation
    always @(posedge i_clk) begin : check_lanes
        lane_res_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_lanes.size() == 0) begin
                $display("%0t: lane %0d sample %0d with nothing expected",
                         $time, o_phase_lane, o_sample);
                errors++;
            end else begin
                want = expected_lanes.pop_front();
                if (o_phase_lane !== want.lane) begin
                    $display("%0t: phase_lane expected %0d, got %0d",
                             $time, want.lane, o_phase_lane);
                    errors++;
                end
                if (o_sample !== want.sample) begin
                    $display("%0t: sample on lane %0d expected %0d, got %0d",
                             $time, want.lane, want.sample, o_sample);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last on lane %0d expected %0b, got %0b",
                             $time, want.lane, want.last, o_last);
                    errors++;
                end
            end
        end
    end

    // main sequence: reset, directed table, random phases, drain
    initial begin
        int produced, n;
        bit got;
        errors     = 0;
        hold_req   = 1'b0;
        burst_left = $urandom_range(1, 24);
        clear_model();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_voice     <= '0;
        i_rate_cv   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                quiesce();
                write_reg(dir_rows[i].idx, CFG_DATA_W'(dir_rows[i].value));
            end else begin
                offer_request(dir_rows[i].voice, dir_rows[i].value, dir_rows[i].typed_mask,
                              dir_rows[i].typed_sample, got);
            end
        end

        // random phases: mostly whole frames in voice order, some stray requests
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            quiesce();
            apply_setting(ph);
            if (ph == 2) hold_req = 1'b1;
            produced = 0;
            while (produced < PHASE_ITEMS) begin
                if ($urandom_range(0, 7) == 0) begin
                    offer_request($urandom_range(0, 15), int'($urandom_range(0, 131071)) - 65536,
                                  3'b000, 0, got);
                    if (got) produced++;
                end else begin
                    n = active_count();
                    for (int v = 0; v < n; v++) begin
                        offer_request(v, rand_cv(), 3'b000, 0, got);
                        if (got) produced++;
                    end
                end
            end
        end

        quiesce();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
